[design/lru_key_value_cache_unit_macros.svh]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_macros.svh
// Assertion macros shared by the cache unit.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define LKVC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lkvc assertion failed");

// cons must hold in the cycle after ante
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

[design/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants of the LRU key-value cache unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int CAP_RESET       = 16;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                    cmd;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed
    {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } rsp_t;

    typedef struct packed
    {
        logic hit;
        logic free_any;
        logic lru_any;
    } match_flags_t;

endpackage

[design/lkvc_lookup.sv]
// ----------------------------------------------------------------------------
// lkvc_lookup
// Parallel key compare, free slot and least recent slot search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_lookup #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic [lkvc_pkg::KEY_W-1:0] key,
    input  logic [lkvc_pkg::KEY_W-1:0] keys      [ENTRIES],
    input  logic [ENTRIES-1:0]         valid,
    input  logic [IDX_W-1:0]           ranks     [ENTRIES],
    input  logic [CNT_W-1:0]           occupancy,
    output lkvc_pkg::match_flags_t     flags,
    output logic [IDX_W-1:0]           hit_idx,
    output logic [IDX_W-1:0]           hit_rank,
    output logic [IDX_W-1:0]           free_idx,
    output logic [IDX_W-1:0]           lru_idx
);

    logic [CNT_W-1:0] lru_rank;

    assign lru_rank = occupancy - CNT_W'(1);

    // lowest index wins for hit and free, highest for lru
    always_comb
    begin
        flags    = '0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid[i] && keys[i] == key)
            begin
                flags.hit = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!valid[i])
            begin
                flags.free_any = 1'b1;
                free_idx       = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid[i] && CNT_W'(ranks[i]) == lru_rank)
            begin
                flags.lru_any = 1'b1;
                lru_idx       = IDX_W'(i);
            end
        end
    end

    assign hit_rank = ranks[hit_idx];

endmodule

[design/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
//
// Requests (get or put of a 32-bit key) enter on req_valid/req_ready; one
// response per request leaves on rsp_valid/rsp_ready, in request order.
// A request is registered on acceptance and resolved, once the response
// register is free, by a parallel compare against all entries plus a rank
// update; the response is registered, so rsp_valid rises only after the
// request has passed the input register and then the response register.
// Throughput is one request per cycle while rsp_ready does not stall the
// response, set by the combinational compare and rank update path.
// A stalled rsp_ready holds the response; the input register still takes
// one more request, then req_ready drops until the response is taken.
// cfg_we/cfg_wdata set the capacity (0 reads as 1, above ENTRIES saturates);
// a write is ignored unless the table is empty.
// Reset clears all valid marks, ranks and the count; capacity is min(16, ENTRIES).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lkvc_pkg::req_t            req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lkvc_pkg::rsp_t            rsp,
    input  logic                      cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_INIT = (lkvc_pkg::CAP_RESET > ENTRIES) ? ENTRIES : lkvc_pkg::CAP_RESET;

    logic                          req_valid_reg, req_valid_next;
    lkvc_pkg::req_t                req_reg;
    logic                          rsp_valid_reg, rsp_valid_next;
    lkvc_pkg::rsp_t                rsp_reg, rsp_next;

    logic [lkvc_pkg::KEY_W-1:0]    key_reg   [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0]    value_reg [ENTRIES];
    logic [ENTRIES-1:0]            valid_reg, valid_next;
    logic [IDX_W-1:0]              rank_reg  [ENTRIES];
    logic [IDX_W-1:0]              rank_next [ENTRIES];
    logic [CNT_W-1:0]              occupancy_reg, occupancy_next;
    logic [CNT_W-1:0]              capacity_reg, capacity_next;

    lkvc_pkg::match_flags_t        flags;
    logic [IDX_W-1:0]              hit_idx;
    logic [IDX_W-1:0]              hit_rank;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              lru_idx;

    logic                          req_fire;
    logic                          stage_fire;
    logic [IDX_W-1:0]              slot;
    logic [CNT_W-1:0]              limit;
    logic                          promote;
    logic                          key_we;
    logic                          value_we;

    assign stage_fire = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !req_valid_reg || stage_fire;
    assign req_fire   = req_valid && req_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    lkvc_lookup #(
        .ENTRIES   (ENTRIES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_lookup (
        .key       (req_reg.lookup_key),
        .keys      (key_reg),
        .valid     (valid_reg),
        .ranks     (rank_reg),
        .occupancy (occupancy_reg),
        .flags     (flags),
        .hit_idx   (hit_idx),
        .hit_rank  (hit_rank),
        .free_idx  (free_idx),
        .lru_idx   (lru_idx)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        occupancy_next = occupancy_reg;
        capacity_next  = capacity_reg;
        slot           = '0;
        limit          = '0;
        promote        = 1'b0;
        key_we         = 1'b0;
        value_we       = 1'b0;

        if (req_fire)
        begin
            req_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            req_valid_next = 1'b0;
        end

        if (stage_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we && occupancy_reg == '0)
        begin
            if (cfg_wdata == '0)
            begin
                capacity_next = CNT_W'(1);
            end
            else if (int'(cfg_wdata) > ENTRIES)
            begin
                capacity_next = CNT_W'(ENTRIES);
            end
            else
            begin
                capacity_next = CNT_W'(cfg_wdata);
            end
        end

        if (stage_fire)
        begin
            if (flags.hit)
            begin
                slot     = hit_idx;
                limit    = CNT_W'(hit_rank);
                promote  = 1'b1;
                value_we = (req_reg.cmd == lkvc_pkg::CMD_PUT);
                rsp_next.hit        = 1'b1;
                rsp_next.read_value = value_we ? req_reg.write_value : value_reg[hit_idx];
            end
            else if (req_reg.cmd == lkvc_pkg::CMD_GET)
            begin
                rsp_next.hit        = 1'b0;
                rsp_next.read_value = lkvc_pkg::MISS_VALUE;
            end
            else
            begin
                promote  = 1'b1;
                key_we   = 1'b1;
                value_we = 1'b1;
                if (occupancy_reg < capacity_reg && flags.free_any)
                begin
                    slot           = free_idx;
                    limit          = occupancy_reg;
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
                else if (flags.lru_any)
                begin
                    slot  = lru_idx;
                    limit = occupancy_reg - CNT_W'(1);
                end
                else
                begin
                    // no free slot within capacity and no lru slot found: reuse slot zero
                    slot           = '0;
                    limit          = '0;
                    occupancy_next = CNT_W'(1);
                end
                valid_next[slot]    = 1'b1;
                rsp_next.hit        = 1'b0;
                rsp_next.read_value = req_reg.write_value;
            end

            if (promote)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && CNT_W'(rank_reg[i]) < limit)
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occupancy_reg <= '0;
            capacity_reg  <= CNT_W'(CAP_INIT);
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            valid_reg     <= valid_next;
            occupancy_reg <= occupancy_next;
            capacity_reg  <= capacity_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
        if (key_we)
        begin
            key_reg[slot] <= req_reg.lookup_key;
        end
        if (value_we)
        begin
            value_reg[slot] <= req_reg.write_value;
        end
    end

    `LKVC_ASSERT_ALWAYS(a_occ_within_cap, clk, rst_n, occupancy_reg <= capacity_reg)
    `LKVC_ASSERT_ALWAYS(a_count_matches_valid, clk, rst_n,
        $countones(valid_reg) == int'(occupancy_reg))
    `LKVC_ASSERT_NEXT(a_put_leaves_entry, clk, rst_n,
        stage_fire && req_reg.cmd == lkvc_pkg::CMD_PUT, occupancy_reg != '0)
    `LKVC_ASSERT_NEXT(a_get_keeps_count, clk, rst_n,
        stage_fire && req_reg.cmd == lkvc_pkg::CMD_GET, $stable(occupancy_reg))

endmodule
